@@ hdl/bums_pkg.sv @@
// ============================================================================
// bums_pkg
// Shared constants and types for the bottom-up merge sorter.
// ============================================================================
package bums_pkg;

    // Capacity of one set (2 .. 64)
    localparam int MAX_ITEMS = 64;

    // Element width, RAM address width and index width (holds 0 .. MAX_ITEMS)
    localparam int DATA_W = 32;
    localparam int ADDR_W = $clog2(MAX_ITEMS);
    localparam int IDX_W  = $clog2(MAX_ITEMS + 1);
    // Room for run bound sums (index plus two run lengths)
    localparam int SUM_W  = IDX_W + 2;

    // Sequencer states
    typedef enum logic [2:0] {
        S_LOAD,
        S_PRIME,
        S_MERGE,
        S_EMIT_RD,
        S_EMIT_LD,
        S_EMIT_WAIT
    } t_state;

endpackage

@@ hdl/bums_if.sv @@
// ============================================================================
// bums_if
// Valid/ready stream interfaces for the sorter's input and result channels.
// ============================================================================

// Input channel: one element per beat, last marks the end of the set
interface bums_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [bums_pkg::DATA_W-1:0] value;
    logic                              last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

// Result channel: one sorted element per beat
interface bums_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [bums_pkg::DATA_W-1:0] sorted_value;
    logic                              last_res;
    logic                              overflow;

    modport source (output valid, output sorted_value, output last_res,
                    output overflow, input ready);
    modport sink   (input valid, input sorted_value, input last_res,
                    input overflow, output ready);
endinterface

@@ hdl/bums_ram.sv @@
// ============================================================================
// bums_ram
// Generic RAM: one write port, two read ports, registered read data.
// ============================================================================
module bums_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr_b,
    output logic [WIDTH-1:0]                 o_rdata_a,
    output logic [WIDTH-1:0]                 o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read ports
    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

@@ hdl/bottom_up_merge_sorter_core.sv @@
// ============================================================================
// bottom_up_merge_sorter_core
// Collects a set of signed 32-bit elements and returns them in ascending order.
// ============================================================================
// Elements are written into the primary buffer at one beat per cycle until a
// beat marked last arrives; beats past capacity are dropped and every result
// of that set then carries overflow. The set is sorted by a bottom-up merge:
// a single comparator walks each pass, writing one element per cycle into the
// other buffer, and the run length doubles from pass to pass. For a set of n
// elements the block loads n beats, makes ceil(log2 n) passes, each opened by
// a priming state, and gives each result beat through the registered read of
// the buffer and then the output register. Input is not ready from the last
// beat of a set until its last result beat has been taken.
// ============================================================================
module bottom_up_merge_sorter_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bums_in_if.sink      i_in,
    bums_out_if.source   o_out
);

    localparam int IDX_W  = bums_pkg::IDX_W;
    localparam int SUM_W  = bums_pkg::SUM_W;
    localparam int ADDR_W = bums_pkg::ADDR_W;
    localparam int DATA_W = bums_pkg::DATA_W;

    // Run bound clipped to the set size
    function automatic logic [IDX_W-1:0] f_clip(input logic [SUM_W-1:0] x,
                                                input logic [IDX_W-1:0] n);
        logic [IDX_W-1:0] res;
        res = (x < SUM_W'(n)) ? x[IDX_W-1:0] : n;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    bums_pkg::t_state    r_state, n_state;
    logic [IDX_W-1:0]    r_count, n_count;     // elements stored (set size)
    logic                r_drop,  n_drop;      // beats dropped in this set
    logic                r_src_sel, n_src_sel; // 0: primary is source
    logic [IDX_W-1:0]    r_len,  n_len;        // run length of current pass
    logic [IDX_W-1:0]    r_p,    n_p;          // left run head
    logic [IDX_W-1:0]    r_q,    n_q;          // right run head
    logic [IDX_W-1:0]    r_mid,  n_mid;        // end of left run
    logic [IDX_W-1:0]    r_hi,   n_hi;         // end of right run
    logic [IDX_W-1:0]    r_k,    n_k;          // write index / emit index
    logic                r_out_valid, n_out_valid;
    logic [DATA_W-1:0]   r_out_value, n_out_value;
    logic                r_out_last,  n_out_last;
    logic                r_out_ovf,   n_out_ovf;

    // Buffer ports
    logic                pri_we, scr_we;
    logic [ADDR_W-1:0]   waddr;
    logic [DATA_W-1:0]   wdata;
    logic [ADDR_W-1:0]   raddr_a, raddr_b;
    logic [DATA_W-1:0]   pri_rd_a, pri_rd_b, scr_rd_a, scr_rd_b;
    logic [DATA_W-1:0]   src_a, src_b;

    // Merge datapath
    logic                take_left;
    logic [IDX_W-1:0]    p1, q1, k1;
    logic                in_beat, out_beat, store_ok;
    logic [IDX_W-1:0]    set_n;
    logic [IDX_W-1:0]    setup_len;
    logic                setup_go;

    // ------------------------------------------------------------------------
    // Ping-pong buffers
    // ------------------------------------------------------------------------
    bums_ram #(.WIDTH(DATA_W), .DEPTH(bums_pkg::MAX_ITEMS)) u_primary (
        .i_clk     (i_clk),
        .i_we      (pri_we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (pri_rd_a),
        .o_rdata_b (pri_rd_b)
    );

    bums_ram #(.WIDTH(DATA_W), .DEPTH(bums_pkg::MAX_ITEMS)) u_scratch (
        .i_clk     (i_clk),
        .i_we      (scr_we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (scr_rd_a),
        .o_rdata_b (scr_rd_b)
    );

    assign src_a = r_src_sel ? scr_rd_a : pri_rd_a;
    assign src_b = r_src_sel ? scr_rd_b : pri_rd_b;

    // Handshakes
    assign i_in.ready = (r_state == bums_pkg::S_LOAD);
    assign in_beat    = i_in.valid && (r_state == bums_pkg::S_LOAD);
    assign out_beat   = r_out_valid && o_out.ready;
    assign store_ok   = (r_count < IDX_W'(bums_pkg::MAX_ITEMS));
    assign set_n      = store_ok ? (r_count + IDX_W'(1)) : r_count;

    // Shared comparator: ties take the right run
    assign take_left = (r_p < r_mid) &&
                       ((r_q >= r_hi) || ($signed(src_a) < $signed(src_b)));
    assign p1 = take_left ? (r_p + IDX_W'(1)) : r_p;
    assign q1 = take_left ? r_q : (r_q + IDX_W'(1));
    assign k1 = r_k + IDX_W'(1);

    // ------------------------------------------------------------------------
    // Sequencer: next state, buffer control
    // ------------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_drop      = r_drop;
        n_src_sel   = r_src_sel;
        n_len       = r_len;
        n_p         = r_p;
        n_q         = r_q;
        n_mid       = r_mid;
        n_hi        = r_hi;
        n_k         = r_k;
        n_out_valid = r_out_valid;
        n_out_value = r_out_value;
        n_out_last  = r_out_last;
        n_out_ovf   = r_out_ovf;
        pri_we      = 1'b0;
        scr_we      = 1'b0;
        waddr       = r_k[ADDR_W-1:0];
        wdata       = take_left ? src_a : src_b;
        raddr_a     = r_p[ADDR_W-1:0];
        raddr_b     = r_q[ADDR_W-1:0];
        setup_go    = 1'b0;
        setup_len   = IDX_W'(1);

        case (r_state)
            // Store beats until the end of the set
            bums_pkg::S_LOAD: begin
                waddr = r_count[ADDR_W-1:0];
                wdata = i_in.value;
                if (in_beat) begin
                    if (store_ok) begin
                        pri_we  = 1'b1;
                        n_count = r_count + IDX_W'(1);
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (i_in.last) begin
                        n_src_sel = 1'b0;
                        n_k       = '0;
                        if (set_n > IDX_W'(1)) begin
                            setup_go  = 1'b1;
                            setup_len = IDX_W'(1);
                        end else begin
                            n_state = bums_pkg::S_EMIT_RD;
                        end
                    end
                end
            end

            // Fetch the two run heads of the first pair
            bums_pkg::S_PRIME: begin
                n_state = bums_pkg::S_MERGE;
            end

            // One element per cycle into the other buffer
            bums_pkg::S_MERGE: begin
                pri_we  = r_src_sel;
                scr_we  = !r_src_sel;
                n_p     = p1;
                n_q     = q1;
                n_k     = k1;
                if (k1 == r_count) begin
                    // End of pass
                    n_src_sel = !r_src_sel;
                    n_k       = '0;
                    if (({2'b00, r_len} << 1) >= SUM_W'(r_count)) begin
                        n_state = bums_pkg::S_EMIT_RD;
                    end else begin
                        setup_go  = 1'b1;
                        setup_len = r_len << 1;
                    end
                end else if (k1 == r_hi) begin
                    // Next pair of runs starts at the old right-run end
                    n_p   = r_hi;
                    n_mid = f_clip(SUM_W'(r_hi) + SUM_W'(r_len), r_count);
                    n_q   = n_mid;
                    n_hi  = f_clip(SUM_W'(r_hi) + (SUM_W'(r_len) << 1), r_count);
                end
                raddr_a = n_p[ADDR_W-1:0];
                raddr_b = n_q[ADDR_W-1:0];
            end

            // Read the next sorted element
            bums_pkg::S_EMIT_RD: begin
                raddr_a = r_k[ADDR_W-1:0];
                n_state = bums_pkg::S_EMIT_LD;
            end

            // Load the output register
            bums_pkg::S_EMIT_LD: begin
                n_out_valid = 1'b1;
                n_out_value = src_a;
                n_out_last  = (k1 == r_count);
                n_out_ovf   = r_drop;
                n_state     = bums_pkg::S_EMIT_WAIT;
            end

            // Hold the beat; on acceptance fetch the next one
            bums_pkg::S_EMIT_WAIT: begin
                raddr_a = k1[ADDR_W-1:0];
                if (out_beat) begin
                    n_out_valid = 1'b0;
                    if (r_out_last) begin
                        n_count = '0;
                        n_drop  = 1'b0;
                        n_state = bums_pkg::S_LOAD;
                    end else begin
                        n_k     = k1;
                        n_state = bums_pkg::S_EMIT_LD;
                    end
                end
            end

            default: begin
                n_state = bums_pkg::S_LOAD;
            end
        endcase

        // Start of a pass: first pair of runs
        if (setup_go) begin
            n_len   = setup_len;
            n_p     = '0;
            n_mid   = f_clip(SUM_W'(setup_len), (r_state == bums_pkg::S_LOAD) ?
                             set_n : r_count);
            n_q     = n_mid;
            n_hi    = f_clip(SUM_W'(setup_len) << 1, (r_state == bums_pkg::S_LOAD) ?
                             set_n : r_count);
            n_k     = '0;
            n_state = bums_pkg::S_PRIME;
        end
    end

    // ------------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bums_pkg::S_LOAD;
            r_count     <= '0;
            r_drop      <= 1'b0;
            r_src_sel   <= 1'b0;
            r_len       <= IDX_W'(1);
            r_p         <= '0;
            r_q         <= '0;
            r_mid       <= '0;
            r_hi        <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_drop      <= n_drop;
            r_src_sel   <= n_src_sel;
            r_len       <= n_len;
            r_p         <= n_p;
            r_q         <= n_q;
            r_mid       <= n_mid;
            r_hi        <= n_hi;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
    end

    // Output payload register
    always_ff @(posedge i_clk) begin
        r_out_value <= n_out_value;
        r_out_last  <= n_out_last;
        r_out_ovf   <= n_out_ovf;
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.sorted_value = r_out_value;
    assign o_out.last_res     = r_out_last;
    assign o_out.overflow     = r_out_ovf;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_drop_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drop |-> (r_count == IDX_W'(bums_pkg::MAX_ITEMS)))
        else $error("drop flag set with room left");

    a_merge_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bums_pkg::S_MERGE) |->
            ((r_p <= r_mid) && (r_q <= r_hi) && (r_k < r_count)))
        else $error("merge heads out of run bounds");

    a_valid_only_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_state == bums_pkg::S_EMIT_WAIT))
        else $error("result beat shown outside emit wait");

    a_last_back_to_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_beat && r_out_last) |=> (i_in.ready && (r_count == '0)))
        else $error("set end did not return to loading");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for the bottom-up merge sorter core: feeds sets of
// signed elements, sorts each accepted set with a local merge sort and checks
// every result beat (value, last marker, overflow flag) in order.
// ============================================================================
module testbench;

    typedef logic signed [bums_pkg::DATA_W-1:0] t_elem;

    // One pending input beat: payload plus its pacing
    typedef struct {
        t_elem       value;
        logic        last;
        bit          drain;   // hold until every predicted result has come
        int unsigned gap;     // idle cycles before offering this beat
    } t_element;

    // One predicted result beat
    typedef struct {
        t_elem sorted_value;
        logic  last_res;
        logic  overflow;
    } t_sorted;

    typedef enum {
        FILL_WIDE,
        FILL_DUPS,
        FILL_EXTREME,
        FILL_ASCEND,
        FILL_DESCEND
    } t_fill;

    localparam t_elem VAL_MIN      = 32'sh8000_0000;
    localparam t_elem VAL_MAX      = 32'sh7FFF_FFFF;
    localparam int    RANDOM_ITEMS = 350;
    localparam int    HOLD_AT      = 120;   // input beats before the long output hold
    localparam int    HOLD_LEN     = 300;
    localparam int    IDLE_LIMIT   = 5000;
    localparam int    TAIL_CYCLES  = 40;

    logic i_clk;
    logic i_rst_n;

    bums_in_if  in_if ();
    bums_out_if out_if ();

    bottom_up_merge_sorter_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_element element_q [$];
    t_sorted  sorted_q [$];
    int       exp_cnt;      // registered copy of sorted_q size
    int       in_beats;
    int       err_cnt;

    // Running copy of the set being collected
    t_elem set_buf [bums_pkg::MAX_ITEMS];
    int    set_cnt;
    bit    set_dropped;

    // Clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Bottom-up merge sort of the first n entries; on equal keys the right
    // run wins; each pass merges into a scratch copy that is copied back
    function automatic void sort_set(ref t_elem vals [bums_pkg::MAX_ITEMS], input int n);
        t_elem scratch [bums_pkg::MAX_ITEMS];
        int    run;
        int    base;
        int    mid;
        int    hi;
        int    p;
        int    q;
        run = 1;
        while (run < n) begin
            for (base = 0; base < n; base += 2 * run) begin
                mid = (base + run < n) ? base + run : n;
                hi  = (base + 2 * run < n) ? base + 2 * run : n;
                p   = base;
                q   = mid;
                for (int k = base; k < hi; k++) begin
                    if (q >= hi || (p < mid && vals[p] < vals[q])) begin
                        scratch[k] = vals[p];
                        p++;
                    end else begin
                        scratch[k] = vals[q];
                        q++;
                    end
                end
            end
            for (int k = 0; k < n; k++) vals[k] = scratch[k];
            run *= 2;
        end
    endfunction

    task automatic add_element(t_elem v, logic l, bit d, int unsigned g);
        t_element e;
        e.value = v;
        e.last  = l;
        e.drain = d;
        e.gap   = g;
        element_q.push_back(e);
    endtask

    // Queue one set of the given size; the last beat carries the marker
    task automatic add_random_set(int size, t_fill fill, bit drain, bit burst);
        t_elem       v;
        t_elem       start;
        int unsigned g;
        start = t_elem'($urandom);
        for (int i = 0; i < size; i++) begin
            case (fill)
                FILL_WIDE:    v = t_elem'($urandom);
                FILL_DUPS:    v = t_elem'($urandom_range(0, 6)) - 3;
                FILL_EXTREME: begin
                    case ($urandom_range(0, 3))
                        0:       v = VAL_MIN;
                        1:       v = VAL_MAX;
                        2:       v = '0;
                        default: v = -1;
                    endcase
                end
                FILL_ASCEND:  v = start + i;
                default:      v = start - i;
            endcase
            g = burst ? 0 : $urandom_range(0, 15);
            add_element(v, i == size - 1, drain && i == 0, g);
        end
    endtask

    // Stimulus, reset and end of run
    initial begin
        int    rand_items;
        int    set_idx;
        int    size;
        t_fill fill;

        in_if.valid  = 1'b0;
        in_if.value  = '0;
        in_if.last   = 1'b0;
        out_if.ready = 1'b0;
        i_rst_n      = 1'b0;
        err_cnt      = 0;

        // Directed: single element, extremes, duplicates, sorted and reversed
        add_element(32'sd5, 1'b1, 1'b0, 0);
        add_element(VAL_MAX, 1'b0, 1'b0, 0);
        add_element(VAL_MIN, 1'b1, 1'b0, 3);
        add_element('0,      1'b0, 1'b0, 0);
        add_element(-1,      1'b0, 1'b0, 1);
        add_element(32'sd1,  1'b0, 1'b0, 0);
        add_element(VAL_MIN, 1'b0, 1'b0, 0);
        add_element(VAL_MAX, 1'b0, 1'b0, 2);
        add_element(-1,      1'b0, 1'b0, 0);
        add_element('0,      1'b1, 1'b0, 0);
        for (int i = 0; i < 5; i++) add_element(t_elem'(i * 7 - 10), i == 4, 1'b0, 0);
        for (int i = 0; i < 5; i++) add_element(t_elem'(40 - i * 9), i == 4, 1'b0, 0);

        // Random sets: mostly small, at least one exactly full, a few past capacity
        rand_items = 0;
        set_idx    = 0;
        while (rand_items < RANDOM_ITEMS) begin
            if (set_idx == 3)
                size = bums_pkg::MAX_ITEMS;
            else if (set_idx == 8 || set_idx == 15)
                size = bums_pkg::MAX_ITEMS + $urandom_range(1, 6);
            else if ($urandom_range(0, 19) == 0)
                size = $urandom_range(bums_pkg::MAX_ITEMS - 6, bums_pkg::MAX_ITEMS + 6);
            else
                size = $urandom_range(1, 12);
            fill = t_fill'($urandom_range(0, 4));
            add_random_set(size, fill, set_idx == 0 || set_idx == 12,
                           $urandom_range(0, 3) == 0);
            rand_items += size;
            set_idx++;
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (element_q.size() != 0 || in_if.valid) @(posedge i_clk);
        while (exp_cnt != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (sorted_q.size() != 0) begin
            $error("%0d predicted results never arrived", sorted_q.size());
            err_cnt++;
        end
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Input driver
    int unsigned gap_cnt;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            gap_cnt     <= 0;
        end else if (!in_if.valid || in_if.ready) begin
            if (element_q.size() == 0) begin
                in_if.valid <= 1'b0;
            end else if (element_q[0].drain && (in_if.valid || exp_cnt != 0)) begin
                in_if.valid <= 1'b0;
            end else if (gap_cnt < element_q[0].gap) begin
                gap_cnt     <= gap_cnt + 1;
                in_if.valid <= 1'b0;
            end else begin
                in_if.valid <= 1'b1;
                in_if.value <= element_q[0].value;
                in_if.last  <= element_q[0].last;
                gap_cnt     <= 0;
                void'(element_q.pop_front());
            end
        end
    end

    // Result receiver: random stalls per beat, bursts, one long hold
    int  stall_left;
    bit  hold_done;
    bit  rx_burst;

    always @(posedge i_clk) begin
        int unsigned draw;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            stall_left   <= 0;
            hold_done    <= 1'b0;
            rx_burst     <= 1'b0;
        end else if (!hold_done && in_beats >= HOLD_AT) begin
            hold_done    <= 1'b1;
            stall_left   <= HOLD_LEN;
            out_if.ready <= 1'b0;
        end else if (out_if.valid && out_if.ready) begin
            draw = rx_burst ? 0 : $urandom_range(0, 15);
            if (out_if.last_res)
                rx_burst <= ($urandom_range(0, 3) == 0);
            if (draw == 0) begin
                out_if.ready <= 1'b1;
            end else begin
                out_if.ready <= 1'b0;
                stall_left   <= draw;
            end
        end else if (stall_left > 0) begin
            stall_left   <= stall_left - 1;
            out_if.ready <= (stall_left == 1);
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    // Monitor: check result beats, predict on input beats
    always @(posedge i_clk) begin
        t_sorted exp;
        if (!i_rst_n) begin
            set_cnt     = 0;
            set_dropped = 1'b0;
            in_beats   <= 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (sorted_q.size() == 0) begin
                    $error("unexpected result beat: sorted_value=%0d", out_if.sorted_value);
                    err_cnt++;
                end else begin
                    exp = sorted_q.pop_front();
                    if (out_if.sorted_value !== exp.sorted_value) begin
                        $error("sorted_value: expected %0d, got %0d",
                               exp.sorted_value, out_if.sorted_value);
                        err_cnt++;
                    end
                    if (out_if.last_res !== exp.last_res) begin
                        $error("last_res: expected %0b, got %0b",
                               exp.last_res, out_if.last_res);
                        err_cnt++;
                    end
                    if (out_if.overflow !== exp.overflow) begin
                        $error("overflow: expected %0b, got %0b",
                               exp.overflow, out_if.overflow);
                        err_cnt++;
                    end
                end
            end

            if (in_if.valid && in_if.ready) begin
                in_beats <= in_beats + 1;
                // beats past capacity are dropped, last one included
                if (set_cnt < bums_pkg::MAX_ITEMS) begin
                    set_buf[set_cnt] = in_if.value;
                    set_cnt++;
                end else begin
                    set_dropped = 1'b1;
                end
                if (in_if.last) begin
                    sort_set(set_buf, set_cnt);
                    for (int k = 0; k < set_cnt; k++) begin
                        exp.sorted_value = set_buf[k];
                        exp.last_res     = (k == set_cnt - 1);
                        exp.overflow     = set_dropped;
                        sorted_q.push_back(exp);
                    end
                    set_cnt     = 0;
                    set_dropped = 1'b0;
                end
            end
        end
        exp_cnt <= sorted_q.size();
    end

    // Watchdog on cycles without any beat
    int idle_cycles;

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

@@ files.f @@
hdl/bums_pkg.sv
hdl/bums_if.sv
hdl/bums_ram.sv
hdl/bottom_up_merge_sorter_core.sv
tb/testbench.sv
